[sv/cbsv_pkg.sv]
// Shared types, codes and constants of the compact binary struct validator.
package cbsv_pkg;

	localparam int MaxDepth   = 16;
	localparam int CountBits  = 24;
	localparam int StackDepth = MaxDepth + 1;
	localparam int DepthBits  = $clog2(StackDepth + 1);
	localparam int SkipBits   = CountBits + 1;
	localparam int QueueDepth = 2;
	localparam logic [3:0] VarintMax = 4'd10;

	// Configuration register indexes
	localparam logic RegExpectMagic = 1'b0;
	localparam logic RegMaxLength   = 1'b1;

	localparam logic [7:0] ByteStop     = 8'h00;
	localparam logic [7:0] ByteStopBase = 8'h01;

	// Bond type codes
	localparam logic [4:0] TyBool    = 5'd2;
	localparam logic [4:0] TyU8      = 5'd3;
	localparam logic [4:0] TyU16     = 5'd4;
	localparam logic [4:0] TyU32     = 5'd5;
	localparam logic [4:0] TyU64     = 5'd6;
	localparam logic [4:0] TyFloat   = 5'd7;
	localparam logic [4:0] TyDouble  = 5'd8;
	localparam logic [4:0] TyString  = 5'd9;
	localparam logic [4:0] TyStruct  = 5'd10;
	localparam logic [4:0] TyList    = 5'd11;
	localparam logic [4:0] TySet     = 5'd12;
	localparam logic [4:0] TyI8      = 5'd14;
	localparam logic [4:0] TyI16     = 5'd15;
	localparam logic [4:0] TyI32     = 5'd16;
	localparam logic [4:0] TyI64     = 5'd17;
	localparam logic [4:0] TyWString = 5'd18;
	localparam logic [4:0] TyStopBase = 5'd1;

	localparam logic [SkipBits-1:0] FloatBytes  = SkipBits'(4);
	localparam logic [SkipBits-1:0] DoubleBytes = SkipBits'(8);

	typedef enum logic [3:0] {
		ST_RUN      = 4'd0,
		ST_OK       = 4'd1,
		ST_BAD_MAGIC = 4'd2,
		ST_BAD_TYPE = 4'd3,
		ST_TOO_DEEP = 4'd4,
		ST_OVER     = 4'd5,
		ST_TRUNC    = 4'd6,
		ST_TRAIL    = 4'd7,
		ST_OVERLONG = 4'd8
	} status_t;

	typedef enum logic [3:0] {
		PH_MAGIC, PH_HEADER, PH_ID8, PH_ID16_LO, PH_ID16_HI, PH_ONE, PH_NUM,
		PH_SKIP, PH_STRLEN, PH_ELEM, PH_COUNT, PH_DONE, PH_FAIL
	} ph_t;

	typedef enum logic {
		FR_STRUCT = 1'b0,
		FR_LIST   = 1'b1
	} frame_kind_t;

	typedef struct packed {
		frame_kind_t          kind;
		logic [4:0]           elem;
		logic [CountBits-1:0] cnt;
	} frame_t;

	// One input request as it travels through the queue
	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} item_t;

	typedef struct packed {
		logic       stop_base;
		logic       value_end;
		logic       value_byte;
		logic [4:0] ftype;
		logic [15:0] fid;
		logic       header_valid;
		status_t    status;
	} result_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0: r = 8'h43;
			2'd1: r = 8'h42;
			2'd2: r = 8'h01;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

[sv/compact_binary_struct_validator_core.sv]
// Top level of the compact binary struct validator: config registers, queue and parser.
//
// Checks a CompactBinary v1 struct fed one byte per request and returns one result
// per byte. A value end that closes containers holds the input while the parser
// walks the container stack one frame per step, for each nested struct STOP and
// each exhausted list or set popped. A two-entry input queue keeps accepting bytes,
// until it is full, while the parser or the output register waits. A change of
// expect_magic applies from the next first byte.
module compact_binary_struct_validator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tuser,   // first_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // status[3:0], header_valid, field_id[15:0],
	                               // field_type[4:0], value_byte, value_end,
	                               // stop_base_seen, zero fill
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data
);
	import cbsv_pkg::*;

	logic        expect_magic_q;
	logic [23:0] max_length_q;
	item_t       s_item, q_item;
	logic        q_valid, q_pop;
	result_t     res;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_magic_q <= 1'b1;
			max_length_q <= 24'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				RegExpectMagic: expect_magic_q <= cfg_data[0];
				RegMaxLength:   max_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_item = '{data: s_tdata, first: s_tuser, last: s_tlast};

	cbsv_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.s_ready (s_tready),
		.s_item  (s_item),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	cbsv_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.expect_magic (expect_magic_q),
		.max_length   (max_length_q),
		.in_valid     (q_valid),
		.in_item      (q_item),
		.in_pop       (q_pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_res      (res)
	);

	assign m_tdata = {3'd0, res.stop_base, res.value_end, res.value_byte, res.ftype,
	                  res.fid, res.header_valid, res.status};

	// A STOP_BASE mark carries the fixed id and type
	a_stop_base: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[28]) |-> (m_tdata[25:21] == TyStopBase && m_tdata[20:5] == 16'd0))
		else $error("stop base result with wrong id or type");

	// A header byte is never a STOP_BASE byte
	a_hdr_sb: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[4] && m_tdata[28]))
		else $error("header and stop base on one byte");

	// The accepting STOP is outside every field
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[3:0] == ST_OK) |-> (!m_tdata[4] && !m_tdata[26] && !m_tdata[27]))
		else $error("accept marked as field byte");

	// The parser takes a byte only from a non-empty queue
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

endmodule

[sv/cbsv_front.sv]
// Input queue: accepts byte requests and holds them for the parser.
module cbsv_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_valid,
	output logic            s_ready,
	input  cbsv_pkg::item_t s_item,
	output logic            q_valid,
	output cbsv_pkg::item_t q_item,
	input  logic            q_pop
);
	import cbsv_pkg::*;

	localparam int PtrBits = $clog2(QueueDepth);

	item_t                mem_q [QueueDepth];
	logic [PtrBits-1:0]   wr_q;
	logic [PtrBits-1:0]   rd_q;
	logic [PtrBits:0]     cnt_q;
	logic                 push;

	assign s_ready = cnt_q != (PtrBits+1)'(QueueDepth);
	assign push    = s_valid && s_ready;
	assign q_valid = cnt_q != '0;
	assign q_item  = mem_q[rd_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
			if (q_pop) rd_q <= (rd_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (PtrBits+1)'(push) - (PtrBits+1)'(q_pop);
		end
	end

	// Store the request
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= s_item;
	end

endmodule

[sv/cbsv_back.sv]
// Parser: walks the struct grammar, keeps the container stack, registers results.
module cbsv_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      expect_magic,
	input  logic [23:0]               max_length,
	input  logic                      in_valid,
	input  cbsv_pkg::item_t           in_item,
	output logic                      in_pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output cbsv_pkg::result_t         out_res
);
	import cbsv_pkg::*;

	typedef struct packed {
		ph_t                 phase;
		status_t             err;
		logic                push;
		logic                clr;
		logic                setskip;
		logic [SkipBits-1:0] skip;
	} sv_res_t;

	// Begin a value of type t at depth d
	function automatic sv_res_t start_value(input logic [4:0] t,
	                                        input logic [DepthBits-1:0] d);
		sv_res_t r;
		r.phase   = PH_HEADER;
		r.err     = ST_RUN;
		r.push    = 1'b0;
		r.clr     = 1'b0;
		r.setskip = 1'b0;
		r.skip    = '0;
		unique case (t) inside
			TyBool, TyU8, TyI8: r.phase = PH_ONE;
			TyU16, TyU32, TyU64, TyI16, TyI32, TyI64: begin
				r.phase = PH_NUM;
				r.clr   = 1'b1;
			end
			TyFloat: begin
				r.phase = PH_SKIP;
				r.setskip = 1'b1;
				r.skip = FloatBytes;
			end
			TyDouble: begin
				r.phase = PH_SKIP;
				r.setskip = 1'b1;
				r.skip = DoubleBytes;
			end
			TyString, TyWString: begin
				r.phase = PH_STRLEN;
				r.clr   = 1'b1;
			end
			TyStruct: begin
				if (d > DepthBits'(MaxDepth)) r.err = ST_TOO_DEEP;
				else r.push = 1'b1;
			end
			TyList, TySet: begin
				if (d > DepthBits'(MaxDepth)) r.err = ST_TOO_DEEP;
				else r.phase = PH_ELEM;
			end
			default: r.err = ST_BAD_TYPE;
		endcase
		return r;
	endfunction

	// State
	ph_t                  phase_q, n_phase;
	logic [1:0]           magic_q, n_magic;
	logic [CountBits-1:0] vlo_q, n_vlo;
	logic                 vhi_q, n_vhi;
	logic [3:0]           vbytes_q, n_vbytes;
	logic [7:0]           idlo_q, n_idlo;
	logic [4:0]           pend_q, n_pend;
	logic [SkipBits-1:0]  skip_q, n_skip;
	logic [DepthBits-1:0] depth_q, n_depth;
	logic                 open_q, n_open;
	logic                 fin_q, n_fin;
	logic [15:0]          cid_q, n_cid;
	logic [4:0]           ctype_q, n_ctype;
	status_t              ecode_q, n_ecode;
	logic                 unwind_q, n_unwind;
	logic                 chv_q, n_chv;
	logic                 cvb_q, n_cvb;
	logic                 clast_q, n_clast;
	frame_t               stk_q [StackDepth];

	logic                 out_valid_q;
	result_t              res_q;

	logic                 slot_free, byte_take, step, emit;
	logic                 wa_en, wb_en;
	logic [DepthBits-1:0] wa_idx, wb_idx;
	frame_t               wa_frame;
	result_t              res;

	assign slot_free = !out_valid_q || out_ready;
	assign byte_take = in_valid && !unwind_q && slot_free;
	assign step      = byte_take || (unwind_q && slot_free);
	assign in_pop    = byte_take;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	// Next state and result of one step
	always_comb begin
		logic [7:0]           b;
		logic                 last, vb, hv, sb, top_end, vd_go, sv_go, fail_out;
		logic                 vdone, vover;
		logic [4:0]           sv_t_in;
		logic [DepthBits-1:0] sv_d_in;
		logic [DepthBits-1:0] d;
		frame_t               fr;
		logic [CountBits-1:0] cdec;
		logic [15:0]          hid;
		logic                 hd_go;
		sv_res_t              sv;
		status_t              err;

		n_phase = phase_q; n_magic = magic_q; n_vlo = vlo_q; n_vhi = vhi_q;
		n_vbytes = vbytes_q; n_idlo = idlo_q; n_pend = pend_q; n_skip = skip_q;
		n_depth = depth_q; n_open = open_q; n_fin = fin_q; n_cid = cid_q;
		n_ctype = ctype_q; n_ecode = ecode_q; n_unwind = 1'b0;
		n_chv = chv_q; n_cvb = cvb_q; n_clast = clast_q;
		wa_en = 1'b0; wb_en = 1'b0; wa_idx = '0; wb_idx = '0; wa_frame = '0;
		b = in_item.data; last = in_item.last;
		vb = 1'b0; hv = 1'b0; sb = 1'b0; top_end = 1'b0;
		vd_go = 1'b0; sv_go = 1'b0; hd_go = 1'b0; fail_out = 1'b0;
		vdone = 1'b0; vover = 1'b0; hid = '0;
		sv_t_in = '0; sv_d_in = '0; d = '0; fr = '0; cdec = '0;
		err = ST_RUN;
		sv = start_value(sv_t_in, sv_d_in);

		if (unwind_q) begin
			vd_go = 1'b1; hv = chv_q; vb = cvb_q; last = clast_q;
		end else begin
			// Restart on the first byte of a blob
			if (in_item.first) begin
				n_phase = expect_magic ? PH_MAGIC : PH_HEADER;
				n_magic = '0; n_vlo = '0; n_vhi = 1'b0; n_vbytes = '0;
				n_idlo = '0; n_pend = '0; n_skip = '0; n_depth = '0;
				n_open = 1'b0; n_fin = 1'b0; n_cid = '0; n_ctype = '0;
				n_ecode = ST_RUN;
			end
			if (n_phase == PH_FAIL) begin
				fail_out = 1'b1;
			end else begin
				vb = n_open;
				// Varint accumulate for numeric phases
				if (n_phase == PH_NUM || n_phase == PH_STRLEN || n_phase == PH_COUNT) begin
					case (n_vbytes)
						4'd0: n_vlo[6:0]   = b[6:0];
						4'd1: n_vlo[13:7]  = b[6:0];
						4'd2: n_vlo[20:14] = b[6:0];
						4'd3: begin
							n_vlo[23:21] = b[2:0];
							n_vhi = n_vhi | (|b[6:3]);
						end
						4'd4, 4'd5, 4'd6, 4'd7, 4'd8: n_vhi = n_vhi | (|b[6:0]);
						4'd9: n_vhi = n_vhi | b[0];
						default: ;
					endcase
					n_vbytes = n_vbytes + 4'd1;
					vdone = !b[7];
					vover = b[7] && (n_vbytes >= VarintMax);
				end
				unique case (n_phase)
					PH_DONE: begin
						err = ST_TRAIL;
						vb = 1'b0;
					end
					PH_MAGIC: begin
						if (b != magic_byte(n_magic)) err = ST_BAD_MAGIC;
						else begin
							if (n_magic == 2'd3) n_phase = PH_HEADER;
							n_magic = n_magic + 2'd1;
						end
					end
					PH_HEADER: begin
						if (b == ByteStop) begin
							if (n_depth == '0) begin
								n_fin = 1'b1;
								n_phase = PH_DONE;
								if (!last) err = ST_TRAIL;
							end else begin
								n_depth = n_depth - 1'b1;
								n_unwind = 1'b1;
							end
						end else if (b == ByteStopBase) begin
							if (n_depth == '0) sb = 1'b1;
						end else begin
							n_pend = b[4:0];
							if (b[7:5] <= 3'd5) begin
								hd_go = 1'b1;
								hid = {13'd0, b[7:5]};
							end else if (b[7:5] == 3'd6) n_phase = PH_ID8;
							else n_phase = PH_ID16_LO;
						end
					end
					PH_ID8: begin
						hd_go = 1'b1;
						hid = {8'd0, b};
					end
					PH_ID16_LO: begin
						n_idlo = b;
						n_phase = PH_ID16_HI;
					end
					PH_ID16_HI: begin
						hd_go = 1'b1;
						hid = {b, n_idlo};
					end
					PH_ONE: vd_go = 1'b1;
					PH_NUM: begin
						if (vover) err = ST_OVERLONG;
						else if (vdone) vd_go = 1'b1;
					end
					PH_SKIP: begin
						if (n_skip != '0) n_skip = n_skip - 1'b1;
						if (n_skip == '0) vd_go = 1'b1;
					end
					PH_STRLEN: begin
						if (vover) err = ST_OVERLONG;
						else if (vdone) begin
							if (n_vhi || n_vlo > max_length) err = ST_OVER;
							else begin
								n_skip = (n_pend == TyWString) ? {n_vlo, 1'b0} : {1'b0, n_vlo};
								if (n_vlo == '0) vd_go = 1'b1;
								else n_phase = PH_SKIP;
							end
						end
					end
					PH_ELEM: begin
						n_pend = b[4:0];
						n_vlo = '0; n_vhi = 1'b0; n_vbytes = '0;
						n_phase = PH_COUNT;
					end
					PH_COUNT: begin
						if (vover) err = ST_OVERLONG;
						else if (vdone) begin
							if (n_vhi || n_vlo > max_length) err = ST_OVER;
							else if (n_vlo == '0) vd_go = 1'b1;
							else if (n_depth > DepthBits'(MaxDepth)) err = ST_TOO_DEEP;
							else begin
								wa_en = 1'b1;
								wa_idx = n_depth;
								wa_frame = '{kind: FR_LIST, elem: n_pend, cnt: n_vlo};
								n_depth = n_depth + 1'b1;
								sv_go = 1'b1;
								sv_t_in = n_pend;
								sv_d_in = n_depth;
							end
						end
					end
					default: err = ST_BAD_TYPE;
				endcase
			end
		end

		// Complete a field header
		if (hd_go) begin
			if (n_depth == '0) begin
				n_cid = hid;
				n_ctype = n_pend;
				n_open = 1'b1;
				hv = 1'b1;
			end
			sv_go = 1'b1;
			sv_t_in = n_pend;
			sv_d_in = n_depth;
		end

		// Close the value at the top of the stack, one frame per step
		if (vd_go) begin
			d = n_depth;
			fr = stk_q[d - 1'b1];
			cdec = fr.cnt - CountBits'(fr.cnt != '0);
			if (d == '0) begin
				top_end = 1'b1;
				n_open = 1'b0;
				n_phase = PH_HEADER;
			end else if (fr.kind == FR_STRUCT) begin
				n_phase = PH_HEADER;
			end else begin
				wa_en = 1'b1;
				wa_idx = d - 1'b1;
				wa_frame = '{kind: FR_LIST, elem: fr.elem, cnt: cdec};
				if (cdec != '0) begin
					sv_go = 1'b1;
					sv_t_in = fr.elem;
					sv_d_in = d;
				end else begin
					n_depth = d - 1'b1;
					n_unwind = 1'b1;
				end
			end
		end

		// Start the next value
		if (sv_go) begin
			sv = start_value(sv_t_in, sv_d_in);
			n_pend = sv_t_in;
			if (sv.err != ST_RUN) err = sv.err;
			else begin
				n_phase = sv.phase;
				if (sv.clr) begin
					n_vlo = '0; n_vhi = 1'b0; n_vbytes = '0;
				end
				if (sv.setskip) n_skip = sv.skip;
				if (sv.push) begin
					wb_en = 1'b1;
					wb_idx = sv_d_in;
					n_depth = sv_d_in + 1'b1;
				end
			end
		end

		// Hold context when more frames must close
		if (n_unwind) begin
			n_chv = hv; n_cvb = vb; n_clast = last;
		end else if (!fail_out) begin
			if (err == ST_RUN && !n_fin && last)
				err = (n_phase == PH_MAGIC) ? ST_BAD_MAGIC : ST_TRUNC;
			if (err != ST_RUN) begin
				n_phase = PH_FAIL;
				n_ecode = err;
			end
		end

		emit = step && !n_unwind;

		// Assemble the result
		res = '0;
		if (fail_out) begin
			res.status = n_ecode;
		end else begin
			res.status = (err != ST_RUN) ? err : (n_fin ? ST_OK : ST_RUN);
			res.header_valid = hv;
			res.value_byte = vb;
			res.value_end = top_end;
			res.stop_base = sb;
			if (vb || hv) begin
				res.fid = n_cid;
				res.ftype = n_ctype;
			end else if (sb) begin
				res.ftype = TyStopBase;
			end
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			magic_q <= '0;
			vbytes_q <= '0;
			depth_q <= '0;
			open_q <= 1'b0;
			fin_q <= 1'b0;
			ecode_q <= ST_RUN;
			unwind_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q <= n_phase;
				magic_q <= n_magic;
				vbytes_q <= n_vbytes;
				depth_q <= n_depth;
				open_q <= n_open;
				fin_q <= n_fin;
				ecode_q <= n_ecode;
				unwind_q <= n_unwind;
			end
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers and container stack
	always_ff @(posedge clk) begin
		if (step) begin
			vlo_q <= n_vlo;
			vhi_q <= n_vhi;
			idlo_q <= n_idlo;
			pend_q <= n_pend;
			skip_q <= n_skip;
			cid_q <= n_cid;
			ctype_q <= n_ctype;
			chv_q <= n_chv;
			cvb_q <= n_cvb;
			clast_q <= n_clast;
			if (wa_en) stk_q[wa_idx] <= wa_frame;
			if (wb_en) stk_q[wb_idx] <= '{kind: FR_STRUCT, elem: '0, cnt: '0};
		end
		if (emit) res_q <= res;
	end

endmodule
